// ===== rtl/scene_crossfade_matrix_mixer_macros.svh =====
// assertion macros shared by the mixer rtl
`ifndef SCENE_CROSSFADE_MATRIX_MIXER_MACROS_SVH
`define SCENE_CROSSFADE_MATRIX_MIXER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SCM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/scm_pkg.sv =====
// package: widths, codes and types of the scene crossfade matrix mixer
package scm_pkg;

  localparam int DEF_TRACKS = 16;
  localparam int DEF_BUSES  = 8;
  localparam int DEF_SCENES = 16;

  localparam int OPC_W   = 4;
  localparam int TRK_FW  = 4;
  localparam int BUS_FW  = 3;
  localparam int SCN_FW  = 4;
  localparam int SMP_W   = 16;
  localparam int GAIN_W  = 13;
  localparam int RAMP_W  = 12;
  localparam int MGAIN_W = 13;
  localparam int ACC_W   = 36;
  localparam int PROD_W  = GAIN_W + 1 + SMP_W;
  localparam int NUM_W   = GAIN_W + 1 + RAMP_W + 1;
  localparam int DIVN_W  = GAIN_W + RAMP_W;
  localparam int EMIT_W  = ACC_W + MGAIN_W + 1;
  localparam int CFG_AW  = 1;
  localparam int CFG_DW  = 13;

  localparam int SHIFT_MAIN = 24;
  localparam int SHIFT_BUS  = 12;
  localparam int MAIN_BUSES = 2;

  localparam logic [RAMP_W-1:0]  RAMP_RESET      = 12'd44;
  localparam logic [MGAIN_W-1:0] MAIN_GAIN_RESET = 13'd2867;

  typedef enum logic [OPC_W-1:0] {
    OP_SAMPLE        = 4'd0,
    OP_SCENE_BUTTON  = 4'd1,
    OP_SCENE_CV      = 4'd2,
    OP_BUS_MUTE      = 4'd3,
    OP_TRACK_MUTE    = 4'd4,
    OP_SOLO          = 4'd5,
    OP_LINK          = 4'd6,
    OP_CLR_MUTES     = 4'd7,
    OP_CLR_BUS_MUTES = 4'd8,
    OP_CLR_SOLOS     = 4'd9,
    OP_GAIN_WRITE    = 4'd10
  } scm_op_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_RAMP_LENGTH = 1'd0,
    CFG_MAIN_GAIN   = 1'd1
  } scm_cfg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_NUM,
    S_DST,
    S_DIV,
    S_MUL,
    S_ACC,
    S_EMIT
  } scm_state_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_stat_t;

endpackage

// ===== rtl/scm_cell.sv =====
// one accumulator cell of the bus ring
module scm_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               shift,
  input  logic signed [scm_pkg::ACC_W-1:0]   din,
  output logic signed [scm_pkg::ACC_W-1:0]   acc
);
  import scm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (shift) begin
      acc <= din;
    end
  end

endmodule

// ===== rtl/scm_div.sv =====
// restoring divider, one quotient bit per cycle
module scm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [scm_pkg::DIVN_W-1:0]    dividend,
  input  logic [scm_pkg::RAMP_W-1:0]    divisor,
  output logic [scm_pkg::DIVN_W-1:0]    quot,
  output scm_pkg::div_stat_t            stat
);
  import scm_pkg::*;

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [RAMP_W-1:0] rem;
  logic [RAMP_W:0]   rem_sh;
  logic [RAMP_W:0]   rem_sub;
  logic              take;
  logic              done;

  assign rem_sh  = {rem, quot[DIVN_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign take    = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(DIVN_W);
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (cnt != '0) begin
      quot <= {quot[DIVN_W-2:0], take};
      rem  <= take ? rem_sub[RAMP_W-1:0] : rem_sh[RAMP_W-1:0];
    end
  end

  assign stat.done   = done;
  assign stat.rem_nz = (rem != '0);

endmodule

// ===== rtl/scene_crossfade_matrix_mixer.sv =====
// Track-to-bus matrix mixer with crossfaded gain scenes. Control transactions leave the
// sequencer idle. A heard sample walks the bus accumulator ring once, one bus per step:
// a step runs S_RD, S_NUM, S_DST, the wait in S_DIV on the serial divider that scales
// the scene difference, S_MUL and S_ACC while a crossfade is set (ramp_length nonzero),
// and only S_RD, S_NUM, S_MUL and S_ACC when ramp_length is zero, so a sample takes 8
// steps at the default bus count. A frame end then shifts the ring out, one bus result
// per cycle while the output is taken. After reset the gain memory is swept to zero, one
// entry per cycle, over SCENES*BUSES*TRACKS (rounded to powers of two) entries, 2048
// by default; no input transaction is taken during the sweep, configuration writes are.
`include "scene_crossfade_matrix_mixer_macros.svh"

module scene_crossfade_matrix_mixer #(
  parameter int TRACKS = scm_pkg::DEF_TRACKS,
  parameter int BUSES  = scm_pkg::DEF_BUSES,
  parameter int SCENES = scm_pkg::DEF_SCENES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [scm_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [scm_pkg::CFG_DW-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [scm_pkg::OPC_W-1:0]          opcode,
  input  logic [scm_pkg::TRK_FW-1:0]         track,
  input  logic [scm_pkg::BUS_FW-1:0]         bus,
  input  logic [scm_pkg::SCN_FW-1:0]         scene,
  input  logic signed [scm_pkg::SMP_W-1:0]   sample,
  input  logic                               track_active,
  input  logic                               frame_end,
  input  logic [scm_pkg::GAIN_W-1:0]         gain_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [scm_pkg::BUS_FW-1:0]         bus_index,
  output logic signed [scm_pkg::SMP_W-1:0]   mix_value,
  output logic                               clipped,
  output logic                               last_bus
);
  import scm_pkg::*;

  localparam int TR_W      = $clog2(TRACKS);
  localparam int BUS_W     = $clog2(BUSES);
  localparam int SC_W      = $clog2(SCENES);
  localparam int PAIRS     = TRACKS / 2;
  localparam int PR_W      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int ADDR_W    = SC_W + BUS_W + TR_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [EMIT_W-1:0] OUT_MAX = EMIT_W'(32767);
  localparam logic signed [EMIT_W-1:0] OUT_MIN = -EMIT_W'(32768);

  scm_state_t state, state_next;

  // configuration and control state
  logic [RAMP_W-1:0]  ramp_length;
  logic [MGAIN_W-1:0] main_gain;
  logic [SC_W-1:0]    cur_scene, prev_scene;
  logic [RAMP_W-1:0]  ramp_cnt;
  logic [TRACKS-1:0]  track_mutes, track_solos;
  logic [BUSES-1:0]   bus_mutes;
  logic [PAIRS-1:0]   pair_links;
  logic [ADDR_W-1:0]  clr_addr;
  logic [BUS_W-1:0]   bcnt;

  // latched item and datapath
  logic [TR_W-1:0]          t_reg;
  logic signed [SMP_W-1:0]  smp_reg;
  logic                     fend_reg;
  logic signed [NUM_W-1:0]  num_reg;
  logic [GAIN_W-1:0]        g_reg;
  logic signed [PROD_W-1:0] prod_reg;

  logic [GAIN_W-1:0] gain_mem [MEM_DEPTH];
  logic [GAIN_W-1:0] g_cur_rd, g_prev_rd;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [GAIN_W-1:0] mem_wdata;

  // index decode of the input fields
  logic [TR_W+TRK_FW-1:0] tr_x;
  logic [BUS_W+BUS_FW-1:0] bs_x;
  logic [SC_W+SCN_FW-1:0]  sc_x;
  logic [PR_W+TRK_FW-1:0]  pr_x, lk_x;
  logic [TR_W-1:0]  t_idx, p_idx;
  logic [BUS_W-1:0] b_idx;
  logic [PR_W-1:0]  pr_idx, lk_idx;
  logic [SC_W-1:0]  cv_scene;
  logic t_ok, b_ok, p_ok, pr_ok, linked, heard, accept;
  logic [TRACKS-1:0] t_bit, mutes_tog, solos_tog;

  assign tr_x   = (TR_W + TRK_FW)'(track);
  assign bs_x   = (BUS_W + BUS_FW)'(bus);
  assign sc_x   = (SC_W + SCN_FW)'(scene);
  assign pr_x   = (PR_W + TRK_FW)'(track);
  assign lk_x   = (PR_W + TRK_FW)'(track >> 1);
  assign t_idx  = tr_x[TR_W-1:0];
  assign p_idx  = t_idx ^ TR_W'(1);
  assign b_idx  = bs_x[BUS_W-1:0];
  assign pr_idx = pr_x[PR_W-1:0];
  assign lk_idx = lk_x[PR_W-1:0];
  assign t_ok   = 32'(track) < 32'(TRACKS);
  assign b_ok   = 32'(bus) < 32'(BUSES);
  assign p_ok   = 32'(track ^ 4'd1) < 32'(TRACKS);
  assign pr_ok  = 32'(track) < 32'(PAIRS);
  assign linked = p_ok && pair_links[lk_idx];
  assign cv_scene = (32'(scene) > 32'(SCENES - 1)) ? SC_W'(SCENES - 1) : sc_x[SC_W-1:0];
  assign heard  = (track_solos != '0) ? track_solos[t_idx] : !track_mutes[t_idx];
  assign t_bit  = TRACKS'(1) << t_idx;

  always_comb begin
    mutes_tog = track_mutes ^ t_bit;
    solos_tog = track_solos ^ t_bit;
    if (linked) begin
      mutes_tog[p_idx] = mutes_tog[t_idx];
      solos_tog[p_idx] = solos_tog[t_idx];
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // bus accumulator ring: cell 0 is the bus at work, the tail takes the new value
  logic signed [ACC_W-1:0] acc [BUSES];
  logic signed [ACC_W-1:0] feed;
  logic signed [ACC_W:0]   sum_w;
  logic                    ring_shift, emit_step, last_step;

  assign sum_w = (ACC_W + 1)'(acc[0]) + (ACC_W + 1)'(prod_reg);
  always_comb begin
    if (state != S_ACC) begin
      feed = '0;
    end else if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
      feed = sum_w[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      feed = sum_w[ACC_W-1:0];
    end
  end

  assign last_step  = (bcnt == BUS_W'(BUSES - 1));
  assign emit_step  = (state == S_EMIT) && (!out_valid || out_ready);
  assign ring_shift = (state == S_ACC) || emit_step;

  for (genvar i = 0; i < BUSES; i++) begin : g_ring
    if (i == BUSES - 1) begin : g_tail
      scm_cell u_cell (.clk(clk), .rst(rst), .shift(ring_shift), .din(feed), .acc(acc[i]));
    end else begin : g_body
      scm_cell u_cell (.clk(clk), .rst(rst), .shift(ring_shift), .din(acc[i+1]),
                       .acc(acc[i]));
    end
  end

  // crossfade divider
  div_stat_t          div_st;
  logic [DIVN_W-1:0]  div_quot;
  logic signed [NUM_W-1:0] num_mag;
  logic               num_neg;
  logic signed [NUM_W-1:0] cur_x, q_u, g_sum;

  assign num_neg = num_reg[NUM_W-1];
  assign num_mag = num_neg ? -num_reg : num_reg;

  scm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DST),
    .dividend (num_mag[DIVN_W-1:0]),
    .divisor  (ramp_length),
    .quot     (div_quot),
    .stat     (div_st)
  );

  // floor for a positive difference, ceiling of the magnitude for a negative one
  assign cur_x = NUM_W'(g_cur_rd);
  assign q_u   = NUM_W'(div_quot) + NUM_W'(num_neg && div_st.rem_nz);
  assign g_sum = num_neg ? cur_x - q_u : cur_x + q_u;

  logic signed [GAIN_W:0]   d_s;
  logic signed [RAMP_W:0]   r_s;
  logic [RAMP_W-1:0]        r_eff;
  assign r_eff = (ramp_cnt > ramp_length) ? ramp_length : ramp_cnt;
  assign d_s   = $signed({1'b0, g_prev_rd}) - $signed({1'b0, g_cur_rd});
  assign r_s   = $signed({1'b0, r_eff});

  // bus output scaling
  logic signed [EMIT_W-1:0] mg_prod, ev;
  logic                     main_sel;
  assign mg_prod  = EMIT_W'(acc[0]) * EMIT_W'($signed({1'b0, main_gain}));
  assign main_sel = 32'(bcnt) < 32'(MAIN_BUSES);
  assign ev       = main_sel ? (mg_prod >>> SHIFT_MAIN) : (EMIT_W'(acc[0]) >>> SHIFT_BUS);

  // gain memory
  assign mem_we    = (state == S_CLEAR) ||
                     (accept && opcode == OP_GAIN_WRITE && t_ok && b_ok);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : {cur_scene, b_idx, t_idx};
  assign mem_wdata = (state == S_CLEAR) ? '0 : gain_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      gain_mem[mem_waddr] <= mem_wdata;
    end
    g_cur_rd  <= gain_mem[{cur_scene, bcnt, t_reg}];
    g_prev_rd <= gain_mem[{prev_scene, bcnt, t_reg}];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept && opcode == OP_SAMPLE) begin
          if (t_ok && track_active && heard) state_next = S_RD;
          else if (frame_end) state_next = S_EMIT;
        end
      end
      S_RD:  state_next = S_NUM;
      S_NUM: state_next = (ramp_length == '0) ? S_MUL : S_DST;
      S_DST: state_next = S_DIV;
      S_DIV: begin
        if (div_st.done) state_next = S_MUL;
      end
      S_MUL: state_next = S_ACC;
      S_ACC: begin
        if (last_step) state_next = fend_reg ? S_EMIT : S_IDLE;
        else state_next = S_RD;
      end
      S_EMIT: begin
        if (emit_step && last_step) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_length <= RAMP_RESET;
      main_gain   <= MAIN_GAIN_RESET;
      cur_scene   <= '0;
      prev_scene  <= '0;
      ramp_cnt    <= '0;
      track_mutes <= '0;
      track_solos <= '0;
      bus_mutes   <= '0;
      pair_links  <= '0;
      clr_addr    <= '0;
      bcnt        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (scm_cfg_t'(cfg_addr))
          CFG_RAMP_LENGTH: ramp_length <= cfg_data[RAMP_W-1:0];
          CFG_MAIN_GAIN:   main_gain   <= cfg_data[MGAIN_W-1:0];
          default: ;
        endcase
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (accept) begin
        bcnt <= '0;
        case (scm_op_t'(opcode))
          OP_SCENE_BUTTON: begin
            if (32'(scene) < 32'(SCENES)) begin
              prev_scene <= cur_scene;
              cur_scene  <= sc_x[SC_W-1:0];
              ramp_cnt   <= ramp_length;
            end
          end
          OP_SCENE_CV: begin
            if (cv_scene != cur_scene) begin
              prev_scene <= cur_scene;
              cur_scene  <= cv_scene;
              ramp_cnt   <= ramp_length;
            end
          end
          OP_BUS_MUTE: begin
            if (b_ok) bus_mutes[b_idx] <= !bus_mutes[b_idx];
          end
          OP_TRACK_MUTE: begin
            if (t_ok) track_mutes <= mutes_tog;
          end
          OP_SOLO: begin
            if (t_ok) track_solos <= solos_tog;
          end
          OP_LINK: begin
            if (pr_ok) pair_links[pr_idx] <= !pair_links[pr_idx];
          end
          OP_CLR_MUTES:     track_mutes <= '0;
          OP_CLR_BUS_MUTES: bus_mutes   <= '0;
          OP_CLR_SOLOS:     track_solos <= '0;
          default: ;
        endcase
      end
      if (state == S_ACC || emit_step) begin
        bcnt <= last_step ? '0 : bcnt + BUS_W'(1);
      end
      if (emit_step && last_step && ramp_cnt != '0) begin
        ramp_cnt <= ramp_cnt - RAMP_W'(1);
      end
      if (emit_step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      t_reg    <= t_idx;
      smp_reg  <= sample;
      fend_reg <= frame_end;
    end
    if (state == S_NUM) begin
      num_reg <= NUM_W'(d_s * r_s);
      g_reg   <= g_cur_rd;
    end
    if (state == S_DIV && div_st.done) begin
      g_reg <= g_sum[GAIN_W-1:0];
    end
    if (state == S_MUL) begin
      prod_reg <= PROD_W'($signed({1'b0, g_reg}) * smp_reg);
    end
    if (emit_step) begin
      bus_index <= BUS_FW'(bcnt);
      last_bus  <= last_step;
      if (bus_mutes[bcnt]) begin
        mix_value <= '0;
        clipped   <= 1'b0;
      end else if (ev > OUT_MAX) begin
        mix_value <= 16'sh7fff;
        clipped   <= 1'b1;
      end else if (ev < OUT_MIN) begin
        mix_value <= -16'sh8000;
        clipped   <= 1'b1;
      end else begin
        mix_value <= ev[SMP_W-1:0];
        clipped   <= 1'b0;
      end
    end
  end

  `SCM_ASSERT_NOW(a_div_done_in_wait, clk, rst, div_st.done, state == S_DIV, "divider done outside wait")
  `SCM_ASSERT_NOW(a_no_accept_clearing, clk, rst, state == S_CLEAR, !in_ready, "ready during memory sweep")
  `SCM_ASSERT_NEXT(a_emit_ends_idle, clk, rst, emit_step && last_step, state == S_IDLE && out_valid && last_bus, "frame emit did not end")

endmodule
